/* hdl/erot_pkg.sv */
// shared types, constants and helpers for the euler point rotator
package erot_pkg;

   localparam int ANGLE_BITS     = 16;
   localparam int TRIG_FRAC_BITS = 15;
   localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
   localparam int COORD_W        = 32;
   localparam int WIDE_W         = 56;
   localparam int CORDIC_STEPS   = 30;
   localparam int STEP_W         = $clog2(CORDIC_STEPS);
   localparam int CORDIC_XW      = 33;
   localparam int CORDIC_ZW      = 32;
   localparam int CSR_IDX_W      = 2;
   localparam logic signed [CORDIC_XW-1:0] CORDIC_GAIN = 33'sd652032874;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PITCH = 2'd0,
      REG_YAW   = 2'd1,
      REG_ROLL  = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] in_x;
      logic signed [COORD_W-1:0] in_y;
      logic signed [COORD_W-1:0] in_z;
   } req_data_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic signed [COORD_W-1:0] out_z;
   } rsp_data_type;

   typedef struct packed {
      logic                  start;
      logic [ANGLE_BITS-1:0] angle;
   } trig_req_type;

   typedef struct packed {
      logic                     busy;
      logic                     done;
      logic signed [TRIG_W-1:0] cos_val;
      logic signed [TRIG_W-1:0] sin_val;
   } trig_rsp_type;

   function automatic logic signed [CORDIC_ZW-1:0] atan_entry(input logic [STEP_W-1:0] i);
      logic signed [CORDIC_ZW-1:0] r;
      case (i)
         5'd0:  r = 32'sh20000000;
         5'd1:  r = 32'sh12E4051E;
         5'd2:  r = 32'sh09FB385B;
         5'd3:  r = 32'sh051111D4;
         5'd4:  r = 32'sh028B0D43;
         5'd5:  r = 32'sh0145D7E1;
         5'd6:  r = 32'sh00A2F61E;
         5'd7:  r = 32'sh00517C55;
         5'd8:  r = 32'sh0028BE53;
         5'd9:  r = 32'sh00145F2F;
         5'd10: r = 32'sh000A2F98;
         5'd11: r = 32'sh000517CC;
         5'd12: r = 32'sh00028BE6;
         5'd13: r = 32'sh000145F3;
         5'd14: r = 32'sh0000A2FA;
         5'd15: r = 32'sh0000517D;
         5'd16: r = 32'sh000028BE;
         5'd17: r = 32'sh0000145F;
         5'd18: r = 32'sh00000A30;
         5'd19: r = 32'sh00000518;
         5'd20: r = 32'sh0000028C;
         5'd21: r = 32'sh00000146;
         5'd22: r = 32'sh000000A3;
         5'd23: r = 32'sh00000051;
         5'd24: r = 32'sh00000029;
         5'd25: r = 32'sh00000014;
         5'd26: r = 32'sh0000000A;
         5'd27: r = 32'sh00000005;
         5'd28: r = 32'sh00000003;
         5'd29: r = 32'sh00000001;
         default: r = '0;
      endcase
      return r;
   endfunction

   // round to nearest, ties up, dropping the trig fraction bits
   function automatic logic signed [WIDE_W-1:0] rnd_trig(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] half;
      half = WIDE_W'(1) <<< (TRIG_FRAC_BITS - 1);
      return (v + half) >>> TRIG_FRAC_BITS;
   endfunction

   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = (WIDE_W'(1) <<< (COORD_W - 1)) - WIDE_W'(1);
      lo = -(WIDE_W'(1) <<< (COORD_W - 1));
      if (v > hi) return hi[COORD_W-1:0];
      if (v < lo) return lo[COORD_W-1:0];
      return v[COORD_W-1:0];
   endfunction

endpackage

/* hdl/erot_cordic.sv */
// iterative cordic giving cosine and sine of one binary phase angle
module erot_cordic import erot_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  trig_req_type trig_req,
   output trig_rsp_type trig_rsp
);

   typedef enum logic [1:0] {ST_IDLE, ST_ROT, ST_FIX} state_type;

   state_type                      state_ff;
   logic [STEP_W-1:0]              step_ff;
   logic signed [CORDIC_XW-1:0]    x_ff, y_ff;
   logic signed [CORDIC_ZW-1:0]    z_ff;
   logic [1:0]                     quad_ff;
   logic                           done_ff;
   logic signed [TRIG_W-1:0]       cos_ff, sin_ff;

   logic [31:0]                    ph_in, sh_in;
   logic signed [CORDIC_XW-1:0]    dx, dy;
   logic signed [CORDIC_XW-1:0]    cx, sy;
   logic signed [TRIG_W-1:0]       cos_in, sin_in;

   function automatic logic signed [TRIG_W-1:0] trig_fix(input logic signed [CORDIC_XW-1:0] v);
      logic signed [CORDIC_XW:0] w;
      logic signed [CORDIC_XW:0] r;
      logic signed [CORDIC_XW:0] one;
      one = (CORDIC_XW+1)'(1) <<< TRIG_FRAC_BITS;
      w = {v[CORDIC_XW-1], v};
      r = (w + ((CORDIC_XW+1)'(1) <<< (30 - TRIG_FRAC_BITS - 1))) >>> (30 - TRIG_FRAC_BITS);
      if (r > one) r = one;
      if (r < -one) r = -one;
      return r[TRIG_W-1:0];
   endfunction

   always_comb begin
      ph_in = {trig_req.angle, {(32 - ANGLE_BITS){1'b0}}};
      sh_in = ph_in + 32'h20000000;
      dx = y_ff >>> step_ff;
      dy = x_ff >>> step_ff;
      case (quad_ff)
         2'd0: begin cx = x_ff;  sy = y_ff;  end
         2'd1: begin cx = -y_ff; sy = x_ff;  end
         2'd2: begin cx = -x_ff; sy = -y_ff; end
         default: begin cx = y_ff; sy = -x_ff; end
      endcase
      cos_in = trig_fix(cx);
      sin_in = trig_fix(sy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
         step_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (trig_req.start) begin
                  x_ff     <= CORDIC_GAIN;
                  y_ff     <= '0;
                  z_ff     <= $signed({2'b00, sh_in[29:0]}) - 32'sh20000000;
                  quad_ff  <= sh_in[31:30];
                  step_ff  <= '0;
                  state_ff <= ST_ROT;
               end
            end
            ST_ROT: begin
               if (!z_ff[CORDIC_ZW-1]) begin
                  x_ff <= x_ff - dx;
                  y_ff <= y_ff + dy;
                  z_ff <= z_ff - atan_entry(step_ff);
               end else begin
                  x_ff <= x_ff + dx;
                  y_ff <= y_ff - dy;
                  z_ff <= z_ff + atan_entry(step_ff);
               end
               if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
                  state_ff <= ST_FIX;
               end
               step_ff <= step_ff + STEP_W'(1);
            end
            ST_FIX: begin
               cos_ff   <= cos_in;
               sin_ff   <= sin_in;
               done_ff  <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign trig_rsp.busy    = (state_ff != ST_IDLE) || done_ff;
   assign trig_rsp.done    = done_ff;
   assign trig_rsp.cos_val = cos_ff;
   assign trig_rsp.sin_val = sin_ff;

endmodule

/* hdl/euler_point_rotator.sv */
// euler point rotator top level: angle registers, trig storage, rotation pipeline
//
//  channel | ports                        | payload
//  --------+------------------------------+-----------------------------
//  request | req_valid, req_stall         | req_data  (in_x, in_y, in_z)
//  result  | rsp_valid, rsp_stall         | rsp_data  (out_x, out_y, out_z)
//  csr     | csr_valid, csr_ready         | csr_index, csr_wdata
//
// one request per cycle while req_stall is low, results leave in order of acceptance
// a csr write to pitch, yaw or roll runs the cordic, requests stall meanwhile
// after reset all angles are zero and requests are taken at once
// rsp_stall freezes the whole pipeline while a result is waiting, nothing is dropped
module euler_point_rotator import erot_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_data_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_data_type          rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [ANGLE_BITS-1:0] csr_wdata
);

   trig_req_type trig_req;
   trig_rsp_type trig_rsp;

   logic [CSR_IDX_W-1:0]     sel_ff;
   logic signed [TRIG_W-1:0] cx_ff, sx_ff, cy_ff, sy_ff, cz_ff, sz_ff;

   logic advance, csr_wr;
   logic [6:1] v_ff;

   logic signed [WIDE_W-1:0] pa1_ff, pb1_ff, pc1_ff, pd1_ff;
   logic signed [COORD_W-1:0] z1_ff, z2_ff, z3_ff;
   logic signed [WIDE_W-1:0] x1_ff, y1_ff, x1b_ff, x1c_ff;
   logic signed [WIDE_W-1:0] qa_ff, qb_ff, qc_ff, qd_ff;
   logic signed [WIDE_W-1:0] y2_ff, z2w_ff, y2b_ff;
   logic signed [WIDE_W-1:0] ra_ff, rb_ff, rc_ff, rd_ff;
   rsp_data_type             out_ff;

   assign csr_ready = !trig_rsp.busy;
   assign csr_wr    = csr_valid && csr_ready;
   assign trig_req.start = csr_wr && (csr_index == REG_PITCH || csr_index == REG_YAW
                                      || csr_index == REG_ROLL);
   assign trig_req.angle = csr_wdata;

   erot_cordic u_cordic (
      .clock    (clock),
      .reset    (reset),
      .trig_req (trig_req),
      .trig_rsp (trig_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= TRIG_W'(1) <<< TRIG_FRAC_BITS;
         cy_ff <= TRIG_W'(1) <<< TRIG_FRAC_BITS;
         cz_ff <= TRIG_W'(1) <<< TRIG_FRAC_BITS;
         sx_ff <= '0;
         sy_ff <= '0;
         sz_ff <= '0;
         sel_ff <= REG_PITCH;
      end else begin
         if (trig_req.start) sel_ff <= csr_index;
         if (trig_rsp.done) begin
            case (sel_ff)
               REG_PITCH: begin cx_ff <= trig_rsp.cos_val; sx_ff <= trig_rsp.sin_val; end
               REG_YAW:   begin cy_ff <= trig_rsp.cos_val; sy_ff <= trig_rsp.sin_val; end
               REG_ROLL:  begin cz_ff <= trig_rsp.cos_val; sz_ff <= trig_rsp.sin_val; end
               default: ;
            endcase
         end
      end
   end

   assign advance   = !v_ff[6] || !rsp_stall;
   assign req_stall = !advance || trig_rsp.busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= {v_ff[5:1], req_valid && !trig_rsp.busy};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         // roll about z
         pa1_ff <= WIDE_W'(cz_ff) * WIDE_W'(req_data.in_x);
         pb1_ff <= WIDE_W'(sz_ff) * WIDE_W'(req_data.in_y);
         pc1_ff <= WIDE_W'(sz_ff) * WIDE_W'(req_data.in_x);
         pd1_ff <= WIDE_W'(cz_ff) * WIDE_W'(req_data.in_y);
         z1_ff  <= req_data.in_z;
         x1_ff  <= rnd_trig(pa1_ff - pb1_ff);
         y1_ff  <= rnd_trig(pc1_ff + pd1_ff);
         z2_ff  <= z1_ff;
         // pitch about x
         qa_ff  <= WIDE_W'(cx_ff) * y1_ff;
         qb_ff  <= WIDE_W'(sx_ff) * WIDE_W'(z2_ff);
         qc_ff  <= WIDE_W'(sx_ff) * y1_ff;
         qd_ff  <= WIDE_W'(cx_ff) * WIDE_W'(z2_ff);
         x1b_ff <= x1_ff;
         z3_ff  <= z2_ff;
         y2_ff  <= rnd_trig(qa_ff - qb_ff);
         z2w_ff <= rnd_trig(qc_ff + qd_ff);
         x1c_ff <= x1b_ff;
         // yaw about y
         ra_ff  <= WIDE_W'(cy_ff) * x1c_ff;
         rb_ff  <= WIDE_W'(sy_ff) * z2w_ff;
         rc_ff  <= WIDE_W'(cy_ff) * z2w_ff;
         rd_ff  <= WIDE_W'(sy_ff) * x1c_ff;
         y2b_ff <= y2_ff;
         out_ff.out_x <= sat_coord(rnd_trig(ra_ff + rb_ff));
         out_ff.out_y <= sat_coord(y2b_ff);
         out_ff.out_z <= sat_coord(rnd_trig(rc_ff - rd_ff));
      end
   end

   assign rsp_valid = v_ff[6];
   assign rsp_data  = out_ff;

endmodule

/* hdl/erot_checker.sv */
// port level checks for the euler point rotator, bound to the top level
module erot_checker import erot_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input rsp_data_type          rsp_data,
   input logic                  csr_valid,
   input logic                  csr_ready,
   input logic [CSR_IDX_W-1:0]  csr_index
);

   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("result dropped under stall");

   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data)) else $error("stalled result changed");

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      !csr_ready |-> req_stall) else $error("request taken while angles update");

   a_write_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && (csr_index == REG_PITCH || csr_index == REG_YAW
                                 || csr_index == REG_ROLL) |=> !csr_ready && req_stall)
      else $error("angle write did not start trig update");

endmodule

bind euler_point_rotator erot_checker u_erot_checker (.*);

/* bench/testbench.sv */
// self-checking testbench for the euler point rotator
`timescale 1ns / 1ps

module testbench;
   import erot_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;
   localparam int LIMIT = 300000;

   typedef struct {
      req_data_type vec;
      bit           typed;
      rsp_data_type want;
   } vec_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_data_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_data_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [ANGLE_BITS-1:0] csr_wdata = '0;

   logic [ANGLE_BITS-1:0] pitch_q, yaw_q, roll_q;
   rsp_data_type rotated_q[$];
   int mismatches = 0;
   int cycles = 0;
   bit quiet = 0;
   bit long_hold = 0;

   const longint arctan_q30[30] = '{
      'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43,
      'h0145D7E1, 'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F,
      'h000A2F98, 'h000517CC, 'h00028BE6, 'h000145F3, 'h0000A2FA,
      'h0000517D, 'h000028BE, 'h0000145F, 'h00000A30, 'h00000518,
      'h0000028C, 'h00000146, 'h000000A3, 'h00000051, 'h00000029,
      'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001};

   euler_point_rotator uut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint round_q(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint to_trig(longint q30);
      longint v;
      v = round_q(q30, 30 - TRIG_FRAC_BITS);
      if (v > (1 << TRIG_FRAC_BITS)) v = 1 << TRIG_FRAC_BITS;
      if (v < -(1 << TRIG_FRAC_BITS)) v = -(1 << TRIG_FRAC_BITS);
      return v;
   endfunction

   task automatic phase_trig(input logic [ANGLE_BITS-1:0] ang, output longint c,
                             output longint s);
      logic [31:0] sh;
      longint x, y, z, dx, dy, cx, sy;
      sh = {ang, {(32 - ANGLE_BITS){1'b0}}} + 32'h20000000;
      z = longint'(sh[29:0]) - 'h20000000;
      x = 652032874;
      y = 0;
      for (int i = 0; i < 30; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= arctan_q30[i];
         end else begin
            x += dx; y -= dy; z += arctan_q30[i];
         end
      end
      case (sh[31:30])
         2'd0: begin cx = x; sy = y; end
         2'd1: begin cx = -y; sy = x; end
         2'd2: begin cx = -x; sy = -y; end
         default: begin cx = y; sy = -x; end
      endcase
      c = to_trig(cx);
      s = to_trig(sy);
   endtask

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFFFFFF;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   task automatic rotate_vec(input req_data_type d, output rsp_data_type r);
      longint cx, sx, cy, sy, cz, sz, x, y, z, x1, y1, y2, z2, x3, z3;
      phase_trig(pitch_q, cx, sx);
      phase_trig(yaw_q, cy, sy);
      phase_trig(roll_q, cz, sz);
      x = d.in_x; y = d.in_y; z = d.in_z;
      x1 = round_q(cz * x - sz * y, TRIG_FRAC_BITS);
      y1 = round_q(sz * x + cz * y, TRIG_FRAC_BITS);
      y2 = round_q(cx * y1 - sx * z, TRIG_FRAC_BITS);
      z2 = round_q(sx * y1 + cx * z, TRIG_FRAC_BITS);
      x3 = round_q(cy * x1 + sy * z2, TRIG_FRAC_BITS);
      z3 = round_q(cy * z2 - sy * x1, TRIG_FRAC_BITS);
      r.out_x = clamp32(x3);
      r.out_y = clamp32(y2);
      r.out_z = clamp32(z3);
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic send_vec(input req_data_type d, input bit typed, input rsp_data_type want);
      rsp_data_type r;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= d;
      do @(posedge clock); while (req_stall);
      if (typed) r = want;
      else rotate_vec(d, r);
      rotated_q.push_back(r);
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (rotated_q.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic write_angle(input logic [CSR_IDX_W-1:0] idx, input logic [ANGLE_BITS-1:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_PITCH: pitch_q = v;
         REG_YAW:   yaw_q = v;
         REG_ROLL:  roll_q = v;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic signed [31:0] rand_coord();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return $signed($urandom_range(0, 32'h3FFFFF)) - 32'sh200000;
   endfunction

   task automatic random_run(input int n);
      req_data_type d;
      for (int i = 0; i < n; i++) begin
         d.in_x = rand_coord();
         d.in_y = rand_coord();
         d.in_z = rand_coord();
         send_vec(d, 0, '0);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_data_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rotated_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", rsp_data);
         end else begin
            e = rotated_q.pop_front();
            if (e !== rsp_data) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h %h %h, got %h %h %h", e.out_x, e.out_y,
                           e.out_z, rsp_data.out_x, rsp_data.out_y, rsp_data.out_z);
            end
         end
      end
   end

   // result side backpressure
   always @(negedge clock) begin
      static int hold = 0;
      if (hold > 0) hold--;
      else if (long_hold) begin
         hold = 300;
         long_hold = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) hold = $urandom_range(1, 3);
      rsp_stall <= (hold > 0);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      vec_row_type rows[$];
      vec_row_type row;
      req_data_type v;
      pitch_q = '0;
      yaw_q = '0;
      roll_q = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // identity after reset
      rows = '{};
      for (int i = 0; i < 6; i++) begin
         case (i)
            0: v = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh00000000};
            1: v = '{32'sh80000000, 32'sh7FFFFFFF, 32'shFFFFFFFF};
            2: v = '{32'sh00010000, 32'sh00000001, 32'sh80000000};
            3: v = '{32'shAAAAAAAA, 32'sh55555555, 32'sh7FFFFFFF};
            4: v = '{32'sh55555555, 32'shAAAAAAAA, 32'shFFFF0000};
            default: v = '{32'sh00000000, 32'sh00000000, 32'sh00000000};
         endcase
         row.vec = v;
         row.typed = 1;
         row.want = '{v.in_x, v.in_y, v.in_z};
         rows.push_back(row);
      end
      foreach (rows[i]) send_vec(rows[i].vec, rows[i].typed, rows[i].want);
      drain();

      // half turn about z saturates the most negative inputs
      write_angle(REG_ROLL, 16'h8000);
      rows = '{};
      for (int i = 0; i < 4; i++) begin
         case (i)
            0: v = '{32'sh80000000, 32'sh80000000, 32'sh12345678};
            1: v = '{32'sh7FFFFFFF, 32'sh00010000, 32'sh80000000};
            2: v = '{32'sh00000001, 32'shFFFFFFFF, 32'sh7FFFFFFF};
            default: v = '{32'sh00000000, 32'sh00000000, 32'sh00000000};
         endcase
         row.vec = v;
         row.typed = 1;
         row.want = '{clamp32(-longint'(v.in_x)), clamp32(-longint'(v.in_y)), v.in_z};
         rows.push_back(row);
      end
      foreach (rows[i]) send_vec(rows[i].vec, rows[i].typed, rows[i].want);
      drain();

      // quarter turns about x and y, near half turn about z, checked by prediction
      write_angle(REG_PITCH, 16'h4000);
      write_angle(REG_YAW, 16'hC000);
      write_angle(REG_ROLL, 16'h7FFF);
      write_angle(REG_UNUSED, 16'h1234);
      for (int i = 0; i < 8; i++) begin
         v.in_x = (i & 1) ? 32'sh7FFFFFFF : 32'sh80000000;
         v.in_y = (i & 2) ? 32'sh00010000 : 32'shFFFF0000;
         v.in_z = (i & 4) ? 32'sh7FFFFFFF : 32'sh80000000;
         send_vec(v, 0, '0);
      end
      random_run(150);
      drain();

      for (int p = 0; p < 7; p++) begin
         case (p)
            0: begin write_angle(REG_PITCH, 16'h8000); write_angle(REG_YAW, 16'h8000);
                     write_angle(REG_ROLL, 16'h0000); end
            1: begin write_angle(REG_PITCH, 16'h7FFF); write_angle(REG_YAW, 16'h0001);
                     write_angle(REG_ROLL, 16'hFFFF); end
            default: begin write_angle(REG_PITCH, 16'($urandom));
                     write_angle(REG_YAW, 16'($urandom));
                     write_angle(REG_ROLL, 16'($urandom)); end
         endcase
         if (p == 3) long_hold = 1;
         if (p == 6) quiet = 1;
         random_run(180);
         drain();
      end

      repeat (20) @(negedge clock);
      if (mismatches == 0 && rotated_q.size() == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

/* filelist.f */
hdl/erot_pkg.sv
hdl/erot_cordic.sv
hdl/euler_point_rotator.sv
hdl/erot_checker.sv
bench/testbench.sv
